// File: hw/rtl/elfp_pkg.sv
// ----------------------------------------------------------------------------
// elfp_pkg: relocation patcher shared types
// Relocation kinds, decode table, stage payloads and instruction field packers.
// ----------------------------------------------------------------------------
package elfp_pkg;

  typedef enum logic [5:0] {
    K_NONE          = 6'd0,
    K_B16           = 6'd1,  K_B21           = 6'd2,  K_B26           = 6'd3,
    K_ABS_HI20      = 6'd4,  K_ABS_LO12      = 6'd5,
    K_ABS64_LO20    = 6'd6,  K_ABS64_HI12    = 6'd7,
    K_PCALA_HI20    = 6'd8,  K_PCALA_LO12    = 6'd9,
    K_PCALA64_LO20  = 6'd10, K_PCALA64_HI12  = 6'd11,
    K_GOT_PC_HI20   = 6'd12, K_GOT_PC_LO12   = 6'd13,
    K_GOT64_PC_LO20 = 6'd14, K_GOT64_PC_HI12 = 6'd15,
    K_GOT_HI20      = 6'd16, K_GOT_LO12      = 6'd17,
    K_GOT64_LO20    = 6'd18, K_GOT64_HI12    = 6'd19,
    K_TLE_HI20      = 6'd20, K_TLE_LO12      = 6'd21,
    K_TLE64_LO20    = 6'd22, K_TLE64_HI12    = 6'd23,
    K_TIE_PC_HI20   = 6'd24, K_TIE_PC_LO12   = 6'd25,
    K_TIE64_PC_LO20 = 6'd26, K_TIE64_PC_HI12 = 6'd27,
    K_TIE_HI20      = 6'd28, K_TIE_LO12      = 6'd29,
    K_TIE64_LO20    = 6'd30, K_TIE64_HI12    = 6'd31,
    K_TLD_PC_HI20   = 6'd32, K_TGD_PC_HI20   = 6'd33,
    K_TLD_HI20      = 6'd34, K_TGD_HI20      = 6'd35,
    K_ADD6  = 6'd36, K_ADD8  = 6'd37, K_ADD16 = 6'd38, K_ADD32 = 6'd39, K_ADD64 = 6'd40,
    K_SUB6  = 6'd41, K_SUB8  = 6'd42, K_SUB16 = 6'd43, K_SUB32 = 6'd44, K_SUB64 = 6'd45,
    K_PCREL32 = 6'd46, K_PCREL64 = 6'd47
  } kind_e;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,  OP_B16    = 4'd1,  OP_B21    = 4'd2,  OP_B26    = 4'd3,
    OP_HI20   = 4'd4,  OP_LO12   = 4'd5,  OP_LO20   = 4'd6,  OP_HI12   = 4'd7,
    OP_PCHI20 = 4'd8,  OP_PCLO20 = 4'd9,  OP_PCHI12 = 4'd10, OP_ADD6   = 4'd11,
    OP_ADD    = 4'd12, OP_SUB6   = 4'd13, OP_SUB    = 4'd14, OP_PCREL  = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    SRC_SA = 2'd0,
    SRC_GA = 2'd1,
    SRC_TA = 2'd2
  } src_e;

  localparam logic [63:0] PageMask = 64'hFFFF_FFFF_FFFF_F000;
  localparam logic [63:0] PageHalf = 64'h800;

  typedef struct packed {
    op_e        op;
    src_e       src;
    logic [3:0] bytes;
  } desc_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [63:0] old_word;
    logic [63:0] sym;
    logic [63:0] addend;
    logic [63:0] place;
    logic [63:0] slot;
    logic [63:0] thunk;
  } req_t;

  // operand stage out: target value known
  typedef struct packed {
    op_e         op;
    logic [3:0]  bytes;
    logic [63:0] v;
    logic [63:0] tx;
    logic [63:0] place;
    logic [63:0] old_word;
  } opnd_t;

  // offset stage out: differences, checks, data sums
  typedef struct packed {
    op_e         op;
    logic [3:0]  bytes;
    logic [63:0] v;
    logic [63:0] x;
    logic [63:0] boff;
    logic [63:0] pchi;
    logic [63:0] sum;
    logic [63:0] dif;
    logic [63:0] old_word;
    logic        rerr;
    logic        aerr;
  } offs_t;

  typedef struct packed {
    logic [63:0] new_word;
    logic [3:0]  write_bytes;
    logic        range_error;
    logic        align_error;
  } res_t;

  function automatic desc_t kind_desc(logic [5:0] kind);
    desc_t d;
    d = '{OP_NONE, SRC_SA, 4'd0};
    case (kind_e'(kind))
      K_B16:           d = '{OP_B16,    SRC_SA, 4'd4};
      K_B21:           d = '{OP_B21,    SRC_SA, 4'd4};
      K_B26:           d = '{OP_B26,    SRC_SA, 4'd4};
      K_ABS_HI20:      d = '{OP_HI20,   SRC_SA, 4'd4};
      K_ABS_LO12:      d = '{OP_LO12,   SRC_SA, 4'd4};
      K_ABS64_LO20:    d = '{OP_LO20,   SRC_SA, 4'd4};
      K_ABS64_HI12:    d = '{OP_HI12,   SRC_SA, 4'd4};
      K_PCALA_HI20:    d = '{OP_PCHI20, SRC_SA, 4'd4};
      K_PCALA_LO12:    d = '{OP_LO12,   SRC_SA, 4'd4};
      K_PCALA64_LO20:  d = '{OP_PCLO20, SRC_SA, 4'd4};
      K_PCALA64_HI12:  d = '{OP_PCHI12, SRC_SA, 4'd4};
      K_GOT_PC_HI20, K_TIE_PC_HI20, K_TLD_PC_HI20, K_TGD_PC_HI20:
                       d = '{OP_PCHI20, SRC_GA, 4'd4};
      K_GOT_PC_LO12, K_TIE_PC_LO12, K_GOT_LO12, K_TIE_LO12:
                       d = '{OP_LO12,   SRC_GA, 4'd4};
      K_GOT64_PC_LO20, K_TIE64_PC_LO20:
                       d = '{OP_PCLO20, SRC_GA, 4'd4};
      K_GOT64_PC_HI12, K_TIE64_PC_HI12:
                       d = '{OP_PCHI12, SRC_GA, 4'd4};
      K_GOT_HI20, K_TIE_HI20, K_TLD_HI20, K_TGD_HI20:
                       d = '{OP_HI20,   SRC_GA, 4'd4};
      K_GOT64_LO20, K_TIE64_LO20:
                       d = '{OP_LO20,   SRC_GA, 4'd4};
      K_GOT64_HI12, K_TIE64_HI12:
                       d = '{OP_HI12,   SRC_GA, 4'd4};
      K_TLE_HI20:      d = '{OP_HI20,   SRC_TA, 4'd4};
      K_TLE_LO12:      d = '{OP_LO12,   SRC_TA, 4'd4};
      K_TLE64_LO20:    d = '{OP_LO20,   SRC_TA, 4'd4};
      K_TLE64_HI12:    d = '{OP_HI12,   SRC_TA, 4'd4};
      K_ADD6:          d = '{OP_ADD6,   SRC_SA, 4'd1};
      K_ADD8:          d = '{OP_ADD,    SRC_SA, 4'd1};
      K_ADD16:         d = '{OP_ADD,    SRC_SA, 4'd2};
      K_ADD32:         d = '{OP_ADD,    SRC_SA, 4'd4};
      K_ADD64:         d = '{OP_ADD,    SRC_SA, 4'd8};
      K_SUB6:          d = '{OP_SUB6,   SRC_SA, 4'd1};
      K_SUB8:          d = '{OP_SUB,    SRC_SA, 4'd1};
      K_SUB16:         d = '{OP_SUB,    SRC_SA, 4'd2};
      K_SUB32:         d = '{OP_SUB,    SRC_SA, 4'd4};
      K_SUB64:         d = '{OP_SUB,    SRC_SA, 4'd8};
      K_PCREL32:       d = '{OP_PCREL,  SRC_SA, 4'd4};
      K_PCREL64:       d = '{OP_PCREL,  SRC_SA, 4'd8};
      default:         d = '{OP_NONE,   SRC_SA, 4'd0};
    endcase
    return d;
  endfunction

  function automatic logic [31:0] put_j20(logic [31:0] w, logic [19:0] f);
    return (w & 32'hFE00_001F) | {7'd0, f, 5'd0};
  endfunction

  function automatic logic [31:0] put_k12(logic [31:0] w, logic [11:0] f);
    return (w & 32'hFFC0_03FF) | {10'd0, f, 10'd0};
  endfunction

  function automatic logic [31:0] put_k16(logic [31:0] w, logic [15:0] f);
    return (w & 32'hFC00_03FF) | {6'd0, f, 10'd0};
  endfunction

  function automatic logic [31:0] put_d5k16(logic [31:0] w, logic [20:0] f);
    return (w & 32'hFC00_03E0) | {6'd0, f[15:0], 5'd0, f[20:16]};
  endfunction

  function automatic logic [31:0] put_d10k16(logic [31:0] w, logic [25:0] f);
    return (w & 32'hFC00_0000) | {6'd0, f[15:0], f[25:16]};
  endfunction

  function automatic logic [63:0] byte_mask(logic [3:0] bytes);
    logic [63:0] m;
    case (bytes)
      4'd1:    m = 64'h0000_0000_0000_00FF;
      4'd2:    m = 64'h0000_0000_0000_FFFF;
      4'd4:    m = 64'h0000_0000_FFFF_FFFF;
      4'd8:    m = 64'hFFFF_FFFF_FFFF_FFFF;
      default: m = 64'h0;
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/elfp_front.sv
// ----------------------------------------------------------------------------
// elfp_front: decode and operand stages
// Stage 1 decodes the kind and picks the base; stage 2 adds the addend.
// ----------------------------------------------------------------------------
module elfp_front import elfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  req_t        in_i,
  input  logic [63:0] tp_i,
  output logic        out_valid_o,
  output opnd_t       out_o
);

  typedef struct packed {
    op_e         op;
    logic [3:0]  bytes;
    logic [63:0] base;
    logic [63:0] addend;
    logic [63:0] place;
    logic [63:0] old_word;
    logic [63:0] thunk;
  } dec_t;

  desc_t desc;
  dec_t  dec_d, dec_q;
  opnd_t opnd_d, opnd_q;
  logic  dec_vld_q, opnd_vld_q;

  always_comb begin
    desc = kind_desc(in_i.kind);
    dec_d.op       = desc.op;
    dec_d.bytes    = desc.bytes;
    case (desc.src)
      SRC_GA:  dec_d.base = in_i.slot;
      SRC_TA:  dec_d.base = in_i.sym - tp_i;   // local-exec: S - tp, A added next
      default: dec_d.base = in_i.sym;
    endcase
    dec_d.addend   = in_i.addend;
    dec_d.place    = in_i.place;
    dec_d.old_word = in_i.old_word;
    dec_d.thunk    = in_i.thunk;
  end

  always_comb begin
    opnd_d.op       = dec_q.op;
    opnd_d.bytes    = dec_q.bytes;
    opnd_d.v        = dec_q.base + dec_q.addend;
    opnd_d.tx       = dec_q.thunk + dec_q.addend;
    opnd_d.place    = dec_q.place;
    opnd_d.old_word = dec_q.old_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_vld_q  <= 1'b0;
      opnd_vld_q <= 1'b0;
    end else begin
      dec_vld_q  <= in_valid_i;
      opnd_vld_q <= dec_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      dec_q <= dec_d;
    end
    if (dec_vld_q) begin
      opnd_q <= opnd_d;
    end
  end

  assign out_valid_o = opnd_vld_q;
  assign out_o       = opnd_q;

endmodule

// File: hw/rtl/elfp_offset.sv
// ----------------------------------------------------------------------------
// elfp_offset: PC-relative offset stages
// Stage 3 forms the raw differences; stage 4 the page delta, branch checks
// and the data add/subtract sums.
// ----------------------------------------------------------------------------
module elfp_offset import elfp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  opnd_t in_i,
  output logic  out_valid_o,
  output offs_t out_o
);

  typedef struct packed {
    op_e         op;
    logic [3:0]  bytes;
    logic [63:0] v;
    logic [63:0] x;
    logic [63:0] tdiff;
    logic [63:0] vpage;
    logic [63:0] ppage;
    logic [63:0] old_word;
  } diff_t;

  diff_t diff_d, diff_q;
  offs_t offs_d, offs_q;
  logic  diff_vld_q, offs_vld_q;
  logic  fit17, fit22, fit27;

  always_comb begin
    diff_d.op       = in_i.op;
    diff_d.bytes    = in_i.bytes;
    diff_d.v        = in_i.v;
    diff_d.x        = in_i.v - in_i.place;
    diff_d.tdiff    = in_i.tx - in_i.place;
    diff_d.vpage    = (in_i.v + PageHalf) & PageMask;
    diff_d.ppage    = in_i.place & PageMask;
    diff_d.old_word = in_i.old_word;
  end

  // signed fit: all bits from n up equal the sign
  assign fit17 = (&diff_q.x[63:17]) | ~(|diff_q.x[63:17]);
  assign fit22 = (&diff_q.x[63:22]) | ~(|diff_q.x[63:22]);
  assign fit27 = (&diff_q.x[63:27]) | ~(|diff_q.x[63:27]);

  always_comb begin
    offs_d.op       = diff_q.op;
    offs_d.bytes    = diff_q.bytes;
    offs_d.v        = diff_q.v;
    offs_d.x        = diff_q.x;
    offs_d.boff     = fit27 ? diff_q.x : diff_q.tdiff;  // far B26 goes via thunk
    offs_d.pchi     = diff_q.vpage - diff_q.ppage;
    offs_d.sum      = diff_q.old_word + diff_q.v;
    offs_d.dif      = diff_q.old_word - diff_q.v;
    offs_d.old_word = diff_q.old_word;
    offs_d.aerr     = ((diff_q.op == OP_B16) || (diff_q.op == OP_B21)) &&
                      (diff_q.x[1:0] != 2'b00);
    offs_d.rerr     = ((diff_q.op == OP_B16) && !fit17) ||
                      ((diff_q.op == OP_B21) && !fit22);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_vld_q <= 1'b0;
      offs_vld_q <= 1'b0;
    end else begin
      diff_vld_q <= in_valid_i;
      offs_vld_q <= diff_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      diff_q <= diff_d;
    end
    if (diff_vld_q) begin
      offs_q <= offs_d;
    end
  end

  assign out_valid_o = offs_vld_q;
  assign out_o       = offs_q;

endmodule

// File: hw/rtl/elfp_pack.sv
// ----------------------------------------------------------------------------
// elfp_pack: field insertion and result register
// Hi64 compensation, instruction field packing, data merges, final flags.
// ----------------------------------------------------------------------------
module elfp_pack import elfp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  offs_t in_i,
  output logic  out_valid_o,
  output res_t  out_o
);

  res_t        res_d, res_q;
  logic        res_vld_q;
  logic [31:0] hi32;
  logic [31:0] w;
  logic [63:0] mask;
  logic        lo_neg, mid_neg, pc_fit;

  assign lo_neg  = in_i.v[11];
  assign mid_neg = in_i.pchi[31];
  assign pc_fit  = (&in_i.pchi[63:31]) | ~(|in_i.pchi[63:31]);
  assign mask    = byte_mask(in_i.bytes);

  // upper half of the page delta, corrected for the sign of lo12 and hi20
  always_comb begin
    if (lo_neg && !mid_neg) begin
      hi32 = in_i.pchi[63:32] - 32'd1;
    end else if (!lo_neg && mid_neg) begin
      hi32 = in_i.pchi[63:32] + 32'd1;
    end else begin
      hi32 = in_i.pchi[63:32];
    end
  end

  always_comb begin
    w = in_i.old_word[31:0];
    case (in_i.op)
      OP_B16:    w = put_k16(in_i.old_word[31:0], in_i.x[17:2]);
      OP_B21:    w = put_d5k16(in_i.old_word[31:0], in_i.x[22:2]);
      OP_B26:    w = put_d10k16(in_i.old_word[31:0], in_i.boff[27:2]);
      OP_HI20:   w = put_j20(in_i.old_word[31:0], in_i.v[31:12]);
      OP_LO12:   w = put_k12(in_i.old_word[31:0], in_i.v[11:0]);
      OP_LO20:   w = put_j20(in_i.old_word[31:0], in_i.v[51:32]);
      OP_HI12:   w = put_k12(in_i.old_word[31:0], in_i.v[63:52]);
      OP_PCHI20: w = put_j20(in_i.old_word[31:0], in_i.pchi[31:12]);
      OP_PCLO20: w = put_j20(in_i.old_word[31:0], hi32[19:0]);
      OP_PCHI12: w = put_k12(in_i.old_word[31:0], hi32[31:20]);
      default:   w = in_i.old_word[31:0];
    endcase
  end

  always_comb begin
    res_d.write_bytes = in_i.bytes;
    res_d.align_error = in_i.aerr;
    res_d.range_error = in_i.rerr || ((in_i.op == OP_PCHI20) && !pc_fit);
    case (in_i.op)
      OP_B16, OP_B21, OP_B26, OP_HI20, OP_LO12, OP_LO20, OP_HI12,
      OP_PCHI20, OP_PCLO20, OP_PCHI12:
        res_d.new_word = {in_i.old_word[63:32], w};
      OP_ADD6:  res_d.new_word = {in_i.old_word[63:6], in_i.sum[5:0]};
      OP_SUB6:  res_d.new_word = {in_i.old_word[63:6], in_i.dif[5:0]};
      OP_ADD:   res_d.new_word = (in_i.old_word & ~mask) | (in_i.sum & mask);
      OP_SUB:   res_d.new_word = (in_i.old_word & ~mask) | (in_i.dif & mask);
      OP_PCREL: res_d.new_word = (in_i.old_word & ~mask) | (in_i.x & mask);
      default:  res_d.new_word = in_i.old_word;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_o       = res_q;

endmodule

// File: hw/rtl/elf_reloc_field_patcher.sv
// ----------------------------------------------------------------------------
// elf_reloc_field_patcher: relocation apply pipeline
// Patches one relocation per cycle into the location word, with flags.
// ----------------------------------------------------------------------------
// One relocation is taken every cycle: busy is never raised, so start may be
// held high back to back. Each result appears on done_o in order, for one
// cycle only, after passing through the five-stage pipeline (decode,
// addend, differences, page delta and checks, field pack). The receiver
// cannot stall, so results must be taken as they appear. thread_pointer is
// written over the cfg channel, which is always ready; write it only while
// no relocation is in flight.
module elf_reloc_field_patcher import elfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [5:0]         req_type_i,
  input  logic [63:0]        old_word_i,
  input  logic [63:0]        sym_addr_i,
  input  logic signed [63:0] addend_i,
  input  logic [63:0]        place_i,
  input  logic [63:0]        slot_addr_i,
  input  logic [63:0]        thunk_addr_i,
  output logic               done_o,
  output logic [63:0]        new_word_o,
  output logic [3:0]         write_bytes_o,
  output logic               range_error_o,
  output logic               align_error_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [63:0]        cfg_data_i
);

  logic [63:0] thread_pointer_q;
  req_t        req;
  logic        accept;
  logic        opnd_vld, offs_vld, res_vld;
  opnd_t       opnd;
  offs_t       offs;
  res_t        res;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thread_pointer_q <= 64'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thread_pointer_q <= cfg_data_i;
    end
  end

  assign req = '{kind:     req_type_i,
                 old_word: old_word_i,
                 sym:      sym_addr_i,
                 addend:   $unsigned(addend_i),
                 place:    place_i,
                 slot:     slot_addr_i,
                 thunk:    thunk_addr_i};

  elfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .in_i        (req),
    .tp_i        (thread_pointer_q),
    .out_valid_o (opnd_vld),
    .out_o       (opnd)
  );

  elfp_offset u_offset (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (opnd_vld),
    .in_i        (opnd),
    .out_valid_o (offs_vld),
    .out_o       (offs)
  );

  elfp_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (offs_vld),
    .in_i        (offs),
    .out_valid_o (res_vld),
    .out_o       (res)
  );

  assign done_o        = res_vld;
  assign new_word_o    = res.new_word;
  assign write_bytes_o = res.write_bytes;
  assign range_error_o = res.range_error;
  assign align_error_o = res.align_error;

  // every result beat traces back to a matching start beat
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 5))
    else $error("result beat without a matching start beat");

  a_start_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 done_o)
    else $error("start beat lost in the pipeline");

  // no-op kinds leave the word untouched and raise nothing
  a_noop_passthru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (write_bytes_o == 4'd0)) |->
      (!range_error_o && !align_error_o && (new_word_o == $past(old_word_i, 5))))
    else $error("no-op relocation changed the word or flagged");

  a_align_is_insn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (align_error_o || range_error_o)) |-> (write_bytes_o == 4'd4))
    else $error("error flag on a non-instruction relocation");

endmodule
